// File: sv/cte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cte_pkg
// Shared types and constants for the cursor template expander: the result
// bundle that carries up to four bytes, character codes and decimal
// conversion constants.
// ============================================================================
package cte_pkg;

    // Most bytes that one template character can produce.
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;

    // Width of the value handed to the decimal converter.
    localparam int DEC_W = 14;

    // Reciprocal constants for division by 10, 100 and 1000 of a DEC_W value.
    localparam logic [15:0] RECIP10   = 16'd52429;
    localparam int          SH10      = 19;
    localparam logic [15:0] RECIP100  = 16'd5243;
    localparam int          SH100     = 19;
    localparam logic [15:0] RECIP1000 = 16'd8389;
    localparam int          SH1000    = 23;

    // Template character codes.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_I = 8'h69;
    localparam logic [7:0] CH_LOWER_R = 8'h72;

    // Minimum digit counts of the decimal forms.
    localparam logic [1:0] MINW_ONE   = 2'd1;
    localparam logic [1:0] MINW_TWO   = 2'd2;
    localparam logic [1:0] MINW_THREE = 2'd3;

    // Bytes produced for one template character; bytes[0] leaves first.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
    } t_result;

endpackage
`default_nettype wire

// File: sv/cte_decimal.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cte_decimal
// Converts a value below ten thousand into ASCII decimal digits, padded with
// leading zeros up to a minimum digit count.
// ============================================================================
module cte_decimal (
    input  wire logic [cte_pkg::DEC_W-1:0] i_value,
    input  wire logic [1:0]                i_min_digits,
    output cte_pkg::t_result               o_res
);
    import cte_pkg::*;

    logic [29:0]      w_p10;
    logic [29:0]      w_p100;
    logic [29:0]      w_p1000;
    logic [10:0]      w_q10;
    logic [7:0]       w_q100;
    logic [4:0]       w_q1000;
    logic [13:0]      w_r0;
    logic [10:0]      w_r1;
    logic [7:0]       w_r2;
    logic [3:0][3:0]  w_dig;
    logic [2:0]       w_nat;
    logic [2:0]       w_num;

    // The three quotients come from independent reciprocal products.
    assign w_p10   = 30'(i_value) * 30'(RECIP10);
    assign w_p100  = 30'(i_value) * 30'(RECIP100);
    assign w_p1000 = 30'(i_value) * 30'(RECIP1000);

    assign w_q10   = w_p10[SH10 +: 11];
    assign w_q100  = w_p100[SH100 +: 8];
    assign w_q1000 = w_p1000[SH1000 +: 5];

    assign w_r0 = i_value - (14'(w_q10) * 14'd10);
    assign w_r1 = w_q10 - (11'(w_q100) * 11'd10);
    assign w_r2 = w_q100 - (8'(w_q1000) * 8'd10);

    assign w_dig[0] = w_r0[3:0];
    assign w_dig[1] = w_r1[3:0];
    assign w_dig[2] = w_r2[3:0];
    assign w_dig[3] = w_q1000[3:0];

    always_comb begin
        if (i_value >= DEC_W'(1000)) begin
            w_nat = 3'd4;
        end else if (i_value >= DEC_W'(100)) begin
            w_nat = 3'd3;
        end else if (i_value >= DEC_W'(10)) begin
            w_nat = 3'd2;
        end else begin
            w_nat = 3'd1;
        end
        w_num = (w_nat > {1'b0, i_min_digits}) ? w_nat : {1'b0, i_min_digits};
    end

    // Most significant digit first.
    always_comb begin
        logic [2:0] pos;
        o_res.count = w_num;
        for (int i = 0; i < MAX_RES; i++) begin
            pos = w_num - 3'd1 - 3'(i);
            if (3'(i) < w_num) begin
                o_res.bytes[i] = CH_ZERO + {4'b0000, w_dig[pos[1:0]]};
            end else begin
                o_res.bytes[i] = 8'h00;
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/cte_expand.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cte_expand
// Expansion state and the decode of one registered template character into
// a result bundle. The state advances when the character is taken.
// ============================================================================
module cte_expand #(
    parameter int PARAM_WIDTH = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire logic [7:0]             i_char,
    input  wire logic [PARAM_WIDTH-1:0] i_first,
    input  wire logic [PARAM_WIDTH-1:0] i_second,
    input  wire logic                   i_start,
    input  wire logic                   i_end,
    output cte_pkg::t_result            o_res
);
    import cte_pkg::*;

    logic [PARAM_WIDTH-1:0] r_saved_first, n_saved_first;
    logic [PARAM_WIDTH-1:0] r_saved_second, n_saved_second;
    logic [PARAM_WIDTH-1:0] r_next_first, n_next_first;
    logic [PARAM_WIDTH-1:0] r_next_second, n_next_second;
    logic [1:0]             r_used, n_used;
    logic                   r_add_one, n_add_one;
    logic                   r_pend_pct, n_pend_pct;
    logic                   r_pend_plus, n_pend_plus;

    logic [PARAM_WIDTH-1:0] w_cur;
    logic [DEC_W-1:0]       w_dec_value;
    logic [1:0]             w_min_digits;
    t_result                w_dec_res;

    cte_decimal u_decimal (
        .i_value      (w_dec_value),
        .i_min_digits (w_min_digits),
        .o_res        (w_dec_res)
    );

    always_comb begin
        // A start mark replaces the whole state before the character is decoded.
        n_saved_first  = i_start ? i_first  : r_saved_first;
        n_saved_second = i_start ? i_second : r_saved_second;
        n_next_first   = i_start ? i_first  : r_next_first;
        n_next_second  = i_start ? i_second : r_next_second;
        n_used         = i_start ? 2'd0 : r_used;
        n_add_one      = i_start ? 1'b0 : r_add_one;
        n_pend_pct     = i_start ? 1'b0 : r_pend_pct;
        n_pend_plus    = i_start ? 1'b0 : r_pend_plus;

        w_cur        = (n_used == 2'd0) ? n_next_first : n_next_second;
        w_dec_value  = DEC_W'(w_cur) + DEC_W'(n_add_one);
        w_min_digits = (i_char == CH_TWO) ? MINW_TWO
                     : ((i_char == CH_THREE) ? MINW_THREE : MINW_ONE);

        o_res.bytes = '0;
        o_res.count = '0;

        if (n_pend_plus) begin
            n_pend_plus = 1'b0;
            if (!n_used[1]) begin
                o_res.bytes[0] = i_char + w_cur[7:0];
                o_res.count    = CNT_W'(1);
                n_used         = n_used + 2'd1;
            end
        end else if (n_pend_pct) begin
            n_pend_pct = 1'b0;
            case (i_char)
                CH_PERCENT: begin
                    o_res.bytes[0] = CH_PERCENT;
                    o_res.count    = CNT_W'(1);
                end
                CH_LOWER_R: begin
                    n_next_first  = n_saved_second;
                    n_next_second = n_saved_first;
                end
                CH_LOWER_I: begin
                    n_add_one = 1'b1;
                end
                CH_DOT: begin
                    if (!n_used[1]) begin
                        o_res.bytes[0] = w_cur[7:0];
                        o_res.count    = CNT_W'(1);
                        n_used         = n_used + 2'd1;
                    end
                end
                CH_LOWER_D, CH_TWO, CH_THREE: begin
                    if (!n_used[1]) begin
                        o_res  = w_dec_res;
                        n_used = n_used + 2'd1;
                    end
                end
                CH_PLUS: begin
                    n_pend_plus = !i_end;
                end
                default: begin
                end
            endcase
        end else if (i_char == CH_PERCENT) begin
            if (i_end) begin
                o_res.bytes[0] = CH_PERCENT;
                o_res.count    = CNT_W'(1);
            end else begin
                n_pend_pct = 1'b1;
            end
        end else begin
            o_res.bytes[0] = i_char;
            o_res.count    = CNT_W'(1);
        end

        if (i_end) begin
            n_pend_pct  = 1'b0;
            n_pend_plus = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved_first  <= '0;
            r_saved_second <= '0;
            r_next_first   <= '0;
            r_next_second  <= '0;
            r_used         <= '0;
            r_add_one      <= 1'b0;
            r_pend_pct     <= 1'b0;
            r_pend_plus    <= 1'b0;
        end else if (i_take) begin
            r_saved_first  <= n_saved_first;
            r_saved_second <= n_saved_second;
            r_next_first   <= n_next_first;
            r_next_second  <= n_next_second;
            r_used         <= n_used;
            r_add_one      <= n_add_one;
            r_pend_pct     <= n_pend_pct;
            r_pend_plus    <= n_pend_plus;
        end
    end

endmodule
`default_nettype wire

// File: sv/cte_result.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cte_result
// Result register: holds the bytes of one template character and hands them
// downstream one per transaction, flagging the last one.
// ============================================================================
module cte_result (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  cte_pkg::t_result      i_res,
    input  wire logic             i_stall,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run
);
    import cte_pkg::*;

    logic                    r_valid, n_valid;
    logic [1:0]              r_idx, n_idx;
    logic [MAX_RES-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]        r_count;
    logic                    w_last;
    logic                    w_send;

    assign w_last  = ({1'b0, r_idx} == (r_count - CNT_W'(1)));
    assign w_send  = r_valid && !i_stall;
    assign o_ready = !r_valid || (w_send && w_last);

    assign o_valid       = r_valid;
    assign o_out_byte    = r_bytes[r_idx];
    assign o_last_of_run = w_last;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (w_send) begin
            if (w_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_count <= i_res.count;
        end
    end

endmodule
`default_nettype wire

// File: sv/cursor_template_expander.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// cursor_template_expander
// Expands a cursor-addressing template, one template character per input
// transaction, into the bytes of the addressing sequence.
// ============================================================================
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+--------------------------------
//  input   | in        | i_valid / o_stall   | i_template_char, i_first_param,
//          |           |                     | i_second_param,
//          |           |                     | i_start_of_template,
//          |           |                     | i_end_of_template
//  output  | out       | o_valid / i_stall   | o_out_byte, o_last_of_run
//
// A template character is held in the input register and is decoded into up
// to four bytes that are loaded into the result register when it is ready. The
// result register sends one byte per cycle while i_stall is low, and it takes
// the next character only as its last byte leaves, so a character costs more
// the more bytes (0 to 4) it has; four-digit decimal forms are the slowest case.
// Bytes leave from the result register, behind the input register. Reset is
// synchronous and active low and returns the expansion state to zero. A stall on
// the output holds the result register, and the input register backs up behind
// it, raising o_stall.
module cursor_template_expander #(
    parameter int PARAM_WIDTH = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input channel.
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [7:0]             i_template_char,
    input  wire logic [PARAM_WIDTH-1:0] i_first_param,
    input  wire logic [PARAM_WIDTH-1:0] i_second_param,
    input  wire logic                   i_start_of_template,
    input  wire logic                   i_end_of_template,
    // Output channel.
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [7:0]                  o_out_byte,
    output logic                        o_last_of_run
);
    import cte_pkg::*;

    // Input register.
    logic                   r_in_valid, n_in_valid;
    logic [7:0]             r_char;
    logic [PARAM_WIDTH-1:0] r_first;
    logic [PARAM_WIDTH-1:0] r_second;
    logic                   r_start;
    logic                   r_end;

    logic    w_accept;
    logic    w_take;
    logic    w_res_ready;
    t_result w_res;

    // The held character moves on whenever the result register can take its
    // bytes; characters that produce nothing still pass through without loading it.
    assign w_take   = r_in_valid && w_res_ready;
    assign o_stall  = r_in_valid && !w_res_ready;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_take) begin
            n_in_valid = 1'b0;
        end
        if (w_accept) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char   <= i_template_char;
            r_first  <= i_first_param;
            r_second <= i_second_param;
            r_start  <= i_start_of_template;
            r_end    <= i_end_of_template;
        end
    end

    cte_expand #(
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_char   (r_char),
        .i_first  (r_first),
        .i_second (r_second),
        .i_start  (r_start),
        .i_end    (r_end),
        .o_res    (w_res)
    );

    // Only characters that produce bytes occupy the result register.
    cte_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_take && (w_res.count != '0)),
        .i_res         (w_res),
        .i_stall       (i_stall),
        .o_ready       (w_res_ready),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire
